// File: rtl/core/mbvs_pkg.sv
package mbvs_pkg;

   localparam int NUM_WORKERS_DEF = 16;
   localparam int AMOUNT_BITS_DEF = 40;
   localparam int BUDGET_BITS     = 40;
   localparam int WORKER_BITS     = 4;
   localparam int MASK_BITS       = 16;
   localparam int TOTAL_NOW_BITS  = 44;
   localparam int MAX_SLOTS       = 16;

   typedef enum logic [1:0] {
      FUNC_LOAD,
      FUNC_SAVE,
      FUNC_REPLY
   } func_type;

   typedef enum logic [1:0] {
      KIND_PROCEED,
      KIND_FREE,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DECIDE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                   done;
      logic                   found;
      logic [WORKER_BITS-1:0] victim;
   } scan_result_type;

endpackage

// File: rtl/core/mbvs_ram.sv
module mbvs_ram #(
   parameter int WIDTH = mbvs_pkg::AMOUNT_BITS_DEF,
   parameter int DEPTH = mbvs_pkg::NUM_WORKERS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/mbvs_store.sv
module mbvs_store #(
   parameter int SLOTS       = mbvs_pkg::MAX_SLOTS,
   parameter int AMOUNT_BITS = mbvs_pkg::AMOUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  logic [AMOUNT_BITS-1:0]   wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [AMOUNT_BITS-1:0]   rd_data
);

   logic [SLOTS-1:0]       valid_ff;
   logic                   rd_valid_ff;
   logic [AMOUNT_BITS-1:0] ram_q;

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   mbvs_ram #(
      .WIDTH (AMOUNT_BITS),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_data = rd_valid_ff ? ram_q : '0;

endmodule

// File: rtl/core/mbvs_scan.sv
module mbvs_scan #(
   parameter int SLOTS       = mbvs_pkg::MAX_SLOTS,
   parameter int AMOUNT_BITS = mbvs_pkg::AMOUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [SLOTS-1:0]             mask,
   output logic                         rd_en,
   output logic [$clog2(SLOTS)-1:0]     rd_addr,
   input  logic [AMOUNT_BITS-1:0]       rd_data,
   output mbvs_pkg::scan_result_type    result
);

   localparam int AW = $clog2(SLOTS);
   localparam int WB = mbvs_pkg::WORKER_BITS;
   localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

   logic                   busy_ff;
   logic [AW-1:0]          idx_ff;
   logic                   pend_ff;
   logic [AW-1:0]          pend_idx_ff;
   logic [AMOUNT_BITS-1:0] best_ff;
   logic                   found_ff;
   logic [AW-1:0]          victim_ff;
   logic                   done_ff;
   logic                   take;

   // strict compare keeps the lowest id on ties and skips zero residency
   assign take    = pend_ff && mask[pend_idx_ff] && (rd_data > best_ff);
   assign rd_en   = busy_ff;
   assign rd_addr = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         pend_ff <= busy_ff;
         done_ff <= pend_ff && (pend_idx_ff == LAST);
         if (start) begin
            busy_ff  <= 1'b1;
            found_ff <= 1'b0;
         end else if (busy_ff && idx_ff == LAST) begin
            busy_ff <= 1'b0;
         end
         if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= idx_ff;
      if (start) begin
         idx_ff  <= '0;
         best_ff <= '0;
      end else begin
         if (busy_ff) begin
            idx_ff <= idx_ff + AW'(1);
         end
         if (take) begin
            best_ff   <= rd_data;
            victim_ff <= pend_idx_ff;
         end
      end
   end

   assign result.done   = done_ff;
   assign result.found  = found_ff;
   assign result.victim = WB'(victim_ff);

endmodule

// File: rtl/core/memory_budget_victim_select_core.sv
// Memory budget victim selector. Keeps a resident-byte counter per worker in a
// small synchronous RAM plus a saturating total, checked against csr_wr_data's
// budget. Each req transaction yields exactly one rsp transaction: proceed,
// free-memory request to a victim, or error. An error or a zero reply goes
// straight to the output state; a save reads and updates its counter first;
// a load or nonzero reply also checks the budget, and if the total is left
// over budget runs the victim scan (over SLOTS = min(NUM_WORKERS,16) counters),
// which reads one counter per cycle through the RAM's single read port. One
// transaction is in work at a time; a new one is taken the cycle after the
// previous result moves into the output register, so a stalled output holds
// off the input.
module memory_budget_victim_select_core #(
   parameter int NUM_WORKERS = mbvs_pkg::NUM_WORKERS_DEF,
   parameter int AMOUNT_BITS = mbvs_pkg::AMOUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [39:0] csr_wr_data,    // memory_budget
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,      // worker[3:0], amount[43:4], eligible_mask[59:44]
   input  logic [1:0]  req_tuser,      // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,      // target[3:0], total_now[47:4]
   output logic [1:0]  rsp_tuser       // kind
);

   localparam int SLOTS = (NUM_WORKERS < mbvs_pkg::MAX_SLOTS) ? NUM_WORKERS
                                                              : mbvs_pkg::MAX_SLOTS;
   localparam int AW    = $clog2(SLOTS);
   localparam int AB    = AMOUNT_BITS;
   localparam int TB    = AMOUNT_BITS + 4;
   localparam int CB    = (TB > mbvs_pkg::BUDGET_BITS) ? TB : mbvs_pkg::BUDGET_BITS;
   localparam int WB    = mbvs_pkg::WORKER_BITS;
   localparam int OB    = mbvs_pkg::TOTAL_NOW_BITS;

   mbvs_pkg::state_type state_ff, state_in;

   logic [1:0]                       func_ff, func_in;
   logic [WB-1:0]                    worker_ff, worker_in;
   logic [AB-1:0]                    amt_ff, amt_in;
   logic [mbvs_pkg::MASK_BITS-1:0]   elig_ff, elig_in;
   logic [AW-1:0]                    addr_ff, addr_in;
   logic                             awaiting_ff, awaiting_in;
   logic [WB-1:0]                    requester_ff, requester_in;
   logic [WB-1:0]                    victim_ff, victim_in;
   logic [SLOTS-1:0]                 held_ff, held_in;
   logic [TB-1:0]                    total_ff, total_in;
   logic [mbvs_pkg::BUDGET_BITS-1:0] budget_ff;
   mbvs_pkg::kind_type               res_kind_ff, res_kind_in;
   logic [WB-1:0]                    res_target_ff, res_target_in;
   logic                             rsp_valid_ff;
   mbvs_pkg::kind_type               rsp_kind_ff;
   logic [WB-1:0]                    rsp_target_ff;
   logic [OB-1:0]                    rsp_total_ff;

   logic [1:0]                       req_func;
   logic [WB-1:0]                    req_worker;
   logic [AB-1:0]                    req_amt;
   logic [mbvs_pkg::MASK_BITS-1:0]   req_mask;
   logic                             worker_ok;
   logic                             load_out;

   logic                             ctl_rd_en;
   logic                             mem_wr_en;
   logic [AB-1:0]                    mem_wr_data;
   logic                             mem_rd_en;
   logic [AW-1:0]                    mem_rd_addr;
   logic [AB-1:0]                    mem_rd_data;

   logic                             scan_start;
   logic                             scan_rd_en;
   logic [AW-1:0]                    scan_rd_addr;
   mbvs_pkg::scan_result_type        scan_res;

   logic [AB:0]                      w_sum;
   logic [AB-1:0]                    w_add;
   logic [AB-1:0]                    w_sub;
   logic [TB-1:0]                    amt_t;
   logic [TB:0]                      t_sum;
   logic [TB-1:0]                    t_add;
   logic [TB-1:0]                    t_sub;
   logic                             over_budget;

   assign req_func   = req_tuser;
   assign req_worker = req_tdata[3:0];
   assign req_amt    = AB'(req_tdata[43:4]);
   assign req_mask   = req_tdata[59:44];
   assign worker_ok  = int'(req_worker) < NUM_WORKERS;

   // saturating counter arithmetic
   assign w_sum       = {1'b0, mem_rd_data} + {1'b0, amt_ff};
   assign w_add       = w_sum[AB] ? '1 : w_sum[AB-1:0];
   assign w_sub       = (amt_ff >= mem_rd_data) ? '0 : mem_rd_data - amt_ff;
   assign amt_t       = TB'(amt_ff);
   assign t_sum       = {1'b0, total_ff} + {1'b0, amt_t};
   assign t_add       = t_sum[TB] ? '1 : t_sum[TB-1:0];
   assign t_sub       = (amt_t >= total_ff) ? '0 : total_ff - amt_t;
   assign over_budget = CB'(total_ff) > CB'(budget_ff);

   assign mem_rd_en   = ctl_rd_en | scan_rd_en;
   assign mem_rd_addr = (state_ff == mbvs_pkg::ST_SCAN) ? scan_rd_addr : addr_ff;

   mbvs_store #(
      .SLOTS       (SLOTS),
      .AMOUNT_BITS (AB)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (addr_ff),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   mbvs_scan #(
      .SLOTS       (SLOTS),
      .AMOUNT_BITS (AB)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .mask    (held_ff),
      .rd_en   (scan_rd_en),
      .rd_addr (scan_rd_addr),
      .rd_data (mem_rd_data),
      .result  (scan_res)
   );

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      worker_in     = worker_ff;
      amt_in        = amt_ff;
      elig_in       = elig_ff;
      addr_in       = addr_ff;
      awaiting_in   = awaiting_ff;
      requester_in  = requester_ff;
      victim_in     = victim_ff;
      held_in       = held_ff;
      total_in      = total_ff;
      res_kind_in   = res_kind_ff;
      res_target_in = res_target_ff;
      req_tready    = 1'b0;
      ctl_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_data   = w_sub;
      scan_start    = 1'b0;
      load_out      = 1'b0;

      unique case (state_ff)
         mbvs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in       = req_func;
               worker_in     = req_worker;
               amt_in        = req_amt;
               elig_in       = req_mask;
               res_kind_in   = mbvs_pkg::KIND_ERROR;
               res_target_in = '0;
               state_in      = mbvs_pkg::ST_EMIT;
               case (req_func) inside
                  mbvs_pkg::FUNC_REPLY: begin
                     if (awaiting_ff && req_amt == '0) begin
                        awaiting_in   = 1'b0;
                        res_kind_in   = mbvs_pkg::KIND_PROCEED;
                        res_target_in = requester_ff;
                     end else if (awaiting_ff) begin
                        addr_in  = AW'(victim_ff);
                        state_in = mbvs_pkg::ST_READ;
                     end
                  end
                  mbvs_pkg::FUNC_LOAD, mbvs_pkg::FUNC_SAVE: begin
                     if (!awaiting_ff && worker_ok) begin
                        addr_in  = AW'(req_worker);
                        state_in = mbvs_pkg::ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mbvs_pkg::ST_READ: begin
            ctl_rd_en = 1'b1;
            state_in  = mbvs_pkg::ST_UPDATE;
         end
         mbvs_pkg::ST_UPDATE: begin
            mem_wr_en = 1'b1;
            case (func_ff)
               mbvs_pkg::FUNC_LOAD: begin
                  mem_wr_data  = w_add;
                  total_in     = t_add;
                  requester_in = worker_ff;
                  held_in      = elig_ff[SLOTS-1:0] & ~(SLOTS'(1) << addr_ff);
                  state_in     = mbvs_pkg::ST_DECIDE;
               end
               mbvs_pkg::FUNC_SAVE: begin
                  total_in      = t_sub;
                  res_kind_in   = mbvs_pkg::KIND_PROCEED;
                  res_target_in = worker_ff;
                  state_in      = mbvs_pkg::ST_EMIT;
               end
               default: begin
                  total_in = t_sub;
                  state_in = mbvs_pkg::ST_DECIDE;
               end
            endcase
         end
         mbvs_pkg::ST_DECIDE: begin
            if (over_budget) begin
               scan_start = 1'b1;
               state_in   = mbvs_pkg::ST_SCAN;
            end else begin
               awaiting_in   = 1'b0;
               res_kind_in   = mbvs_pkg::KIND_PROCEED;
               res_target_in = requester_ff;
               state_in      = mbvs_pkg::ST_EMIT;
            end
         end
         mbvs_pkg::ST_SCAN: begin
            if (scan_res.done) begin
               state_in = mbvs_pkg::ST_EMIT;
               if (scan_res.found) begin
                  awaiting_in   = 1'b1;
                  victim_in     = scan_res.victim;
                  res_kind_in   = mbvs_pkg::KIND_FREE;
                  res_target_in = scan_res.victim;
               end else begin
                  awaiting_in   = 1'b0;
                  res_kind_in   = mbvs_pkg::KIND_PROCEED;
                  res_target_in = requester_ff;
               end
            end
         end
         mbvs_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = mbvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbvs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbvs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         requester_ff <= '0;
         victim_ff    <= '0;
         held_ff      <= '0;
         total_ff     <= '0;
         budget_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         awaiting_ff  <= awaiting_in;
         requester_ff <= requester_in;
         victim_ff    <= victim_in;
         held_ff      <= held_in;
         total_ff     <= total_in;
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      worker_ff     <= worker_in;
      amt_ff        <= amt_in;
      elig_ff       <= elig_in;
      addr_ff       <= addr_in;
      res_kind_ff   <= res_kind_in;
      res_target_ff <= res_target_in;
      if (load_out) begin
         rsp_kind_ff   <= res_kind_ff;
         rsp_target_ff <= res_target_ff;
         rsp_total_ff  <= OB'(total_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_target_ff};

   // scanner finishes only while the sequencer waits for it
   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> state_ff == mbvs_pkg::ST_SCAN)
      else $error("scan done outside scan state");

   // a victim is never the worker whose load caused the overflow
   a_victim_not_requester: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbvs_pkg::ST_EMIT && res_kind_ff == mbvs_pkg::KIND_FREE)
      |-> res_target_ff != requester_ff)
      else $error("free request addressed to requester");

   // waiting for a reply starts only together with a free request
   a_await_with_free: assert property (@(posedge clock) disable iff (reset)
      $rose(awaiting_ff) |-> (state_ff == mbvs_pkg::ST_EMIT &&
                              res_kind_ff == mbvs_pkg::KIND_FREE))
      else $error("awaiting reply without free request");

   // a rejected transaction leaves the total untouched
   a_error_keeps_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbvs_pkg::ST_EMIT && res_kind_ff == mbvs_pkg::KIND_ERROR)
      |-> $stable(total_ff))
      else $error("error transaction changed total");

endmodule
